>>> design/m3i_pkg.sv
// shared types and widths for the 3x3 adjugate inverse pipeline
package m3i_pkg;

  localparam int ElemW   = 32;
  localparam int NumElem = 9;
  localparam int AdjW    = 64;
  localparam int DetW    = 97;
  localparam int DmagW   = 96;
  localparam int DivW    = 97;
  localparam int RemW    = 98;
  localparam int QuotW   = 32;
  localparam int DefaultFracBits = 16;

  typedef logic [NumElem-1:0][ElemW-1:0] mat_t;
  typedef logic [NumElem-1:0][AdjW-1:0]  adj_t;
  typedef logic [2:0][ElemW-1:0]         row_t;

  // one divider lane: partial remainder, numerator bits still to shift in,
  // quotient so far, result sign, overflow seen up front
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] nlo;
    logic [QuotW-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    lane_t [NumElem-1:0] lane;
    logic [DivW-1:0]     dvs;
    logic [ElemW-1:0]    det;
    logic                singular;
  } divw_t;

  typedef struct packed {
    logic [NumElem-1:0][ElemW-1:0] inv;
    logic [ElemW-1:0]              det;
    logic                          singular;
  } res_t;

endpackage

>>> design/m3i_cofactor.sv
// cofactor stage pair: eighteen 32x32 products, then nine differences
module m3i_cofactor (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  m3i_pkg::mat_t mat_i,
  output logic          valid_o,
  input  logic          ready_i,
  output m3i_pkg::adj_t adj_o,
  output m3i_pkg::row_t row0_o
);
  import m3i_pkg::*;

  // operand indexes of x*y - z*w for each adjugate entry
  localparam int unsigned Ix [NumElem][4] = '{
    '{4, 8, 5, 7}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  logic v1_q, v2_q, rdy1, rdy2;
  logic [NumElem-1:0][AdjW-1:0] pa_q, pb_q, pa_d, pb_d;
  row_t  r1_q, r2_q;
  adj_t  adj_q, adj_d;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign adj_o   = adj_q;
  assign row0_o  = r2_q;

  for (genvar k = 0; k < NumElem; k++) begin : g_prod
    logic signed [AdjW-1:0] pa, pb;
    assign pa = $signed(mat_i[Ix[k][0]]) * $signed(mat_i[Ix[k][1]]);
    assign pb = $signed(mat_i[Ix[k][2]]) * $signed(mat_i[Ix[k][3]]);
    assign pa_d[k]  = pa;
    assign pb_d[k]  = pb;
    assign adj_d[k] = pa_q[k] - pb_q[k];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      r1_q <= mat_i[2:0];
    end
    if (rdy2 && v1_q) begin
      adj_q <= adj_d;
      r2_q  <= r1_q;
    end
  end

endmodule

>>> design/m3i_det.sv
// determinant by row-0 expansion, rounding of the determinant, divider setup
module m3i_det #(
  parameter int FRAC_BITS = m3i_pkg::DefaultFracBits
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  m3i_pkg::adj_t  adj_i,
  input  m3i_pkg::row_t  row0_i,
  output logic           valid_o,
  input  logic           ready_i,
  output m3i_pkg::divw_t div_o
);
  import m3i_pkg::*;

  localparam int Stages = 4;
  localparam int NumW   = 2 * FRAC_BITS + 132;

  logic [Stages-1:0] v_q, rdy;

  // stage a: split 32x64 products into 32x32 and 32x33 halves
  logic [2:0][63:0] phi_q, phi_d;
  logic [2:0][64:0] plo_q, plo_d;
  adj_t             adj_a_q;
  // stage b: full 96-bit terms
  logic [2:0][DmagW-1:0] term_q, term_d;
  adj_t                  adj_b_q;
  // stage c: determinant
  logic [DetW-1:0] det_q, det_d;
  adj_t            adj_c_q;
  // stage d: divider setup
  divw_t div_q, div_d;

  always_comb begin
    rdy[Stages-1] = !v_q[Stages-1] || ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[Stages-1];
  assign div_o   = div_q;

  for (genvar c = 0; c < 3; c++) begin : g_term
    logic signed [63:0] ph;
    logic signed [64:0] pl;
    logic signed [DmagW-1:0] t;
    assign ph = $signed(adj_i[3*c][63:32]) * $signed(row0_i[c]);
    assign pl = $signed({1'b0, adj_i[3*c][31:0]}) * $signed(row0_i[c]);
    assign phi_d[c] = ph;
    assign plo_d[c] = pl;
    assign t = $signed({phi_q[c], 32'b0}) + DmagW'($signed(plo_q[c]));
    assign term_d[c] = t;
  end

  always_comb begin
    logic signed [DetW-1:0] s;
    s = DetW'($signed(term_q[0])) + DetW'($signed(term_q[1]))
      + DetW'($signed(term_q[2]));
    det_d = s;
  end

  always_comb begin
    logic [DetW-1:0]  dabs, dsum, dsh;
    logic [DmagW-1:0] ud;
    logic [ElemW-1:0] dlim, dmag;
    logic             dneg;
    logic [AdjW-1:0]  aabs;
    logic [NumW-1:0]  num;
    dneg = det_q[DetW-1];
    dabs = dneg ? (~det_q + DetW'(1)) : det_q;
    ud   = dabs[DmagW-1:0];
    dsum = {1'b0, ud} + (DetW'(1) << (2 * FRAC_BITS - 1));
    dsh  = dsum >> (2 * FRAC_BITS);
    dlim = dneg ? 32'h8000_0000 : 32'h7fff_ffff;
    dmag = (dsh > DetW'(dlim)) ? dlim : dsh[ElemW-1:0];
    div_d.det      = dneg ? (~dmag + ElemW'(1)) : dmag;
    div_d.singular = (det_q == '0);
    div_d.dvs      = {ud, 1'b0};
    for (int k = 0; k < NumElem; k++) begin
      aabs = adj_c_q[k][AdjW-1] ? (~adj_c_q[k] + AdjW'(1)) : adj_c_q[k];
      // numerator 2*|adj|*2^(2f) + |det| rounds the quotient to nearest
      num  = (NumW'(aabs) << (2 * FRAC_BITS + 1)) + NumW'(ud);
      div_d.lane[k].ovf = (num >> QuotW) >= NumW'({ud, 1'b0});
      div_d.lane[k].rem = num[QuotW +: RemW];
      div_d.lane[k].nlo = num[QuotW-1:0];
      div_d.lane[k].quo = '0;
      div_d.lane[k].neg = adj_c_q[k][AdjW-1] ^ dneg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      phi_q   <= phi_d;
      plo_q   <= plo_d;
      adj_a_q <= adj_i;
    end
    if (rdy[1] && v_q[0]) begin
      term_q  <= term_d;
      adj_b_q <= adj_a_q;
    end
    if (rdy[2] && v_q[1]) begin
      det_q   <= det_d;
      adj_c_q <= adj_b_q;
    end
    if (rdy[3] && v_q[2]) begin
      div_q <= div_d;
    end
  end

endmodule

>>> design/m3i_divider.sv
// nine-lane restoring divider, one quotient bit per stage, then saturation
module m3i_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  m3i_pkg::divw_t div_i,
  output logic           valid_o,
  input  logic           ready_i,
  output m3i_pkg::res_t  res_o
);
  import m3i_pkg::*;

  localparam int Steps  = QuotW;
  localparam int Stages = Steps + 1;

  logic [Stages-1:0] v_q, rdy;
  divw_t st_q [Steps];
  divw_t st_in [Steps];
  divw_t st_d [Steps];
  res_t  res_q, res_d;

  function automatic divw_t div_step(divw_t x);
    divw_t          y;
    logic [RemW-1:0] t;
    y = x;
    for (int k = 0; k < NumElem; k++) begin
      t = {x.lane[k].rem[RemW-2:0], x.lane[k].nlo[QuotW-1]};
      y.lane[k].nlo = {x.lane[k].nlo[QuotW-2:0], 1'b0};
      if (t >= RemW'(x.dvs)) begin
        y.lane[k].rem = t - RemW'(x.dvs);
        y.lane[k].quo = {x.lane[k].quo[QuotW-2:0], 1'b1};
      end else begin
        y.lane[k].rem = t;
        y.lane[k].quo = {x.lane[k].quo[QuotW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  always_comb begin
    rdy[Stages-1] = !v_q[Stages-1] || ready_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[Stages-1];
  assign res_o   = res_q;

  for (genvar s = 0; s < Steps; s++) begin : g_step
    if (s == 0) begin : g_first
      assign st_in[s] = div_i;
    end else begin : g_next
      assign st_in[s] = st_q[s-1];
    end
    assign st_d[s] = div_step(st_in[s]);
  end

  // sign and saturation of the finished quotients
  always_comb begin
    logic [ElemW-1:0] lim, mag;
    divw_t            x;
    x = st_q[Steps-1];
    for (int k = 0; k < NumElem; k++) begin
      lim = x.lane[k].neg ? 32'h8000_0000 : 32'h7fff_ffff;
      mag = (x.lane[k].ovf || (x.lane[k].quo > lim)) ? lim : x.lane[k].quo;
      if (x.singular) begin
        res_d.inv[k] = '0;
      end else begin
        res_d.inv[k] = x.lane[k].neg ? (~mag + ElemW'(1)) : mag;
      end
    end
    res_d.det      = x.det;
    res_d.singular = x.singular;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) st_q[0] <= st_d[0];
    for (int s = 1; s < Steps; s++) begin
      if (rdy[s] && v_q[s-1]) st_q[s] <= st_d[s];
    end
    if (rdy[Stages-1] && v_q[Stages-2]) res_q <= res_d;
  end

endmodule

>>> design/matrix3_inverse_adjugate_unit.sv
// top level of the pipelined 3x3 matrix inverse by adjugate
//
// one 3x3 matrix of signed fixed-point entries (FRAC_BITS fraction bits)
// enters per word and one result word leaves per matrix: the nine inverse
// entries and the determinant, each rounded to nearest (ties away from zero)
// and saturated to 32 bits, plus a singular flag in tuser. a new matrix can
// be taken every cycle unless the pipe is full; it passes a 2-stage cofactor
// multiplier, a 4-stage determinant and setup section, a 32-stage
// one-bit-per-stage divider with nine lanes, and the output register. every
// stage has its own valid bit and moves when the next one is free, so gaps
// are squeezed out and back-pressure on the output stalls nothing upstream
// until the pipe is full. when the exact determinant is zero the flag is set
// and the inverse entries read zero.
module matrix3_inverse_adjugate_unit #(
  parameter int FRAC_BITS = m3i_pkg::DefaultFracBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a00 a01 a02 a10 a11 a12 a20 a21 a22, 32 bits each, a00 lowest
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21 inv22 determinant,
  // 32 bits each, inv00 lowest
  output logic [319:0] m_axis_tdata,
  // singular
  output logic [0:0]   m_axis_tuser
);
  import m3i_pkg::*;

  logic  cof_valid, cof_ready, det_valid, det_ready;
  adj_t  adj;
  row_t  row0;
  divw_t div_w;
  res_t  res;

  // cofactor products of the incoming matrix
  m3i_cofactor u_cofactor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .mat_i   (s_axis_tdata),
    .valid_o (cof_valid),
    .ready_i (cof_ready),
    .adj_o   (adj),
    .row0_o  (row0)
  );

  // exact determinant and per-lane numerator and divisor
  m3i_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cof_valid),
    .ready_o (cof_ready),
    .adj_i   (adj),
    .row0_i  (row0),
    .valid_o (det_valid),
    .ready_i (det_ready),
    .div_o   (div_w)
  );

  // adjugate over determinant, the last stage is the output register
  m3i_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (det_valid),
    .ready_o (det_ready),
    .div_i   (div_w),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  assign m_axis_tdata = {res.det, res.inv};
  assign m_axis_tuser = res.singular;

endmodule

>>> test/m3i_inverse_checker.sv
// checker for the 3x3 adjugate inverse: predicts each result word and compares
module m3i_inverse_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [319:0] m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           errors_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import m3i_pkg::*;

  localparam int Frac = DefaultFracBits;

  res_t inverse_q[$];

  // rounded quotient, ties away from zero, saturated to 32 bits
  function automatic logic [31:0] div_round_sat(logic signed [129:0] num,
                                                logic signed [129:0] den);
    logic neg;
    logic [129:0] un, ud, q, lim;
    logic [31:0] mag;
    neg = num[129] ^ den[129];
    un  = num[129] ? -num : num;
    ud  = den[129] ? -den : den;
    q   = (2 * un + ud) / (2 * ud);
    lim = neg ? 130'h8000_0000 : 130'h7fff_ffff;
    mag = (q > lim) ? lim[31:0] : q[31:0];
    return neg ? -mag : mag;
  endfunction

  function automatic longint cofactor(longint x, longint y, longint z, longint w);
    return x * y - z * w;
  endfunction

  function automatic res_t invert(mat_t a);
    longint m [9];
    longint adj [9];
    logic signed [129:0] det, p0, p1, p2, scale, numr;
    res_t r;
    for (int i = 0; i < 9; i++) m[i] = longint'(signed'(a[i]));
    adj[0] = cofactor(m[4], m[8], m[5], m[7]);
    adj[1] = cofactor(m[7], m[2], m[1], m[8]);
    adj[2] = cofactor(m[1], m[5], m[4], m[2]);
    adj[3] = cofactor(m[6], m[5], m[3], m[8]);
    adj[4] = cofactor(m[0], m[8], m[2], m[6]);
    adj[5] = cofactor(m[3], m[2], m[0], m[5]);
    adj[6] = cofactor(m[3], m[7], m[4], m[6]);
    adj[7] = cofactor(m[1], m[6], m[0], m[7]);
    adj[8] = cofactor(m[0], m[4], m[1], m[3]);
    p0 = m[0]; p1 = m[1]; p2 = m[2];
    det = p0 * adj[0] + p1 * adj[3] + p2 * adj[6];
    scale = 130'sd1 <<< (2 * Frac);
    r.det = div_round_sat(det, scale);
    r.singular = (det == 0);
    for (int i = 0; i < 9; i++) begin
      numr = adj[i];
      numr = numr <<< (2 * Frac);
      r.inv[i] = r.singular ? '0 : div_round_sat(numr, det);
    end
    return r;
  endfunction

  assign pending_o = inverse_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    int   bad;
    if (!rst_ni) begin
      errors_o <= 0;
      inverse_q.delete();
    end else begin
      bad = 0;
      if (s_axis_tvalid && s_axis_tready) inverse_q.push_back(invert(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_q.size() == 0) begin
          $error("result word with no matrix outstanding");
          bad = bad + 1;
        end else begin
          want = inverse_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_axis_tdata[32*i +: 32] !== want.inv[i]) begin
              $error("inv%0d%0d expected %h actual %h", i / 3, i % 3, want.inv[i],
                     m_axis_tdata[32*i +: 32]);
              bad = bad + 1;
            end
          if (m_axis_tdata[319:288] !== want.det) begin
            $error("determinant expected %h actual %h", want.det, m_axis_tdata[319:288]);
            bad = bad + 1;
          end
          if (m_axis_tuser[0] !== want.singular) begin
            $error("singular expected %b actual %b", want.singular, m_axis_tuser[0]);
            bad = bad + 1;
          end
        end
      end
      errors_o <= errors_o + bad;
    end
  end
endmodule

>>> test/tb_matrix3_inverse_adjugate_unit.sv
// testbench top for the 3x3 adjugate inverse: stimulus, back-pressure and verdict
module tb_matrix3_inverse_adjugate_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import m3i_pkg::*;

  localparam logic [31:0] One = 32'h0001_0000;
  localparam int Limit = 600000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [319:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  int           errors, pending, cycles;
  bit           drain_done = 1'b0;

  matrix3_inverse_adjugate_unit dut (.*);

  m3i_inverse_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // receiver back-pressure, with quiet stretches of full readiness
  int ready_hold;
  bit ready_free;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("matrix3_inverse_adjugate_unit regression: fail");
      $finish;
    end
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(49) == 0) begin
      ready_free <= ~ready_free;
    end else if (!ready_free) begin
      m_axis_tready <= ~m_axis_tready;
      ready_hold <= m_axis_tready ? gap_len() : $urandom_range(6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  bit send_free;

  task automatic send_matrix(mat_t a);
    int g;
    bit rdy;
    g = send_free ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= a;
    // ready only moves at a rising edge, so its value at the falling edge holds
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  function automatic logic [31:0] small_fix();
    return $urandom_range(8 * 65536) - 4 * 65536;
  endfunction

  function automatic mat_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    mat_t a;
    a = '0;
    a[0] = d0; a[4] = d1; a[8] = d2;
    return a;
  endfunction

  initial begin
    mat_t a;
    int kind;
    send_free = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, its negative, zero, extremes, tiny and rank-deficient
    send_matrix(diag(One, One, One));
    send_matrix(diag(-One, -One, -One));
    send_matrix('0);
    send_matrix({9{32'h7fff_ffff}});
    send_matrix({9{32'h8000_0000}});
    send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    send_matrix(diag(32'd1, 32'd1, 32'd1));           // determinant rounds to zero
    send_matrix(diag(32'hffff_ffff, 32'd1, 32'd1));
    send_matrix(diag(32'd256, 32'd256, 32'd256));
    send_matrix(diag(2 * One, One / 2, 4 * One));
    send_matrix(diag(One / 2 + 1, One, One));
    a = '0; a[2] = One; a[4] = One; a[6] = One;         // anti-diagonal
    send_matrix(a);
    for (int i = 0; i < 9; i++) a[i] = (i + 1) * One;   // rank two
    send_matrix(a);
    for (int i = 0; i < 9; i++) a[i] = {$urandom, $urandom} > 0 ? $urandom : 0;
    a[6] = a[0]; a[7] = a[1]; a[8] = a[2];              // repeated row
    send_matrix(a);
    a = diag(One, One, One); a[1] = 32'h7fff_ffff; a[5] = 32'h8000_0000;
    send_matrix(a);
    for (int i = 0; i < 9; i++) a[i] = 32'hffff_ffff;
    send_matrix(a);

    for (int n = 0; n < 1340; n++) begin
      if (n % 200 == 100) send_free = ~send_free;
      if (n == 600) begin
        // hold off until every outstanding result has come back
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
      end
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) begin
        case (kind)
          0, 1, 2: a[i] = $urandom;
          3, 4, 5: a[i] = small_fix();
          6:       a[i] = $urandom_range(2) == 0 ? 32'h8000_0000 >> $urandom_range(31)
                                                 : small_fix();
          default: a[i] = small_fix() & 32'hffff_0000;
        endcase
      end
      if (kind == 8) begin
        // singular: one column is a copy of another
        a[2] = a[0]; a[5] = a[3]; a[8] = a[6];
      end else if (kind == 9 && $urandom_range(1)) begin
        a[3] = a[0]; a[4] = a[1]; a[5] = a[2];
      end
      send_matrix(a);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("matrix3_inverse_adjugate_unit regression: pass");
    end else begin
      $display("matrix3_inverse_adjugate_unit regression: fail");
    end
    $finish;
  end
endmodule

>>> matrix3_inverse_adjugate_unit.f
design/m3i_pkg.sv
design/m3i_cofactor.sv
design/m3i_det.sv
design/m3i_divider.sv
design/matrix3_inverse_adjugate_unit.sv
test/m3i_inverse_checker.sv
test/tb_matrix3_inverse_adjugate_unit.sv
